/* hdl/pov_column_led_frame_store_assert.svh */
// ---------------------------------------------------------------------------
// POV column frame store assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef POV_COLUMN_LED_FRAME_STORE_ASSERT_SVH
`define POV_COLUMN_LED_FRAME_STORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcl same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcl next-cycle check failed");

`endif

/* hdl/pcl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// POV column frame store package
// Operation codes, controller states, shared structs and pixel helpers.
// ---------------------------------------------------------------------------
package pcl_pkg;

    localparam int ROWS       = 8;
    localparam int PIXEL_W    = 3;
    localparam int ROW_W      = ROWS * PIXEL_W;
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 8;

    localparam logic [2:0] PLANE_RED   = 3'b100;
    localparam logic [2:0] PLANE_GREEN = 3'b010;
    localparam logic [2:0] PLANE_BLUE  = 3'b001;

    typedef enum logic [2:0] {
        OP_LOAD_LATCH    = 3'd0,
        OP_STROBE_RED    = 3'd1,
        OP_STROBE_GREEN  = 3'd2,
        OP_STROBE_BLUE   = 3'd3,
        OP_SET_TIMER     = 3'd4,
        OP_TICK          = 3'd5,
        OP_READ_PIXEL    = 3'd6,
        OP_READ_ROTATION = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEM,
        ST_DIV,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        column_event;
        logic        rotation_event;
        logic [7:0]  current_column;
        logic [11:0] read_value;
        logic        range_error;
    } result_t;

    function automatic logic [2:0] plane_of(input op_t op);
        logic [2:0] plane;
        case (op)
            OP_STROBE_RED:   plane = PLANE_RED;
            OP_STROBE_GREEN: plane = PLANE_GREEN;
            OP_STROBE_BLUE:  plane = PLANE_BLUE;
            default:         plane = 3'b000;
        endcase
        return plane;
    endfunction

    function automatic logic [ROW_W-1:0] apply_plane(input logic [ROW_W-1:0] row,
                                                     input logic [2:0]       plane,
                                                     input logic [ROWS-1:0]  bits);
        logic [ROW_W-1:0] res;
        res = row;
        for (int r = 0; r < ROWS; r++)
        begin
            if (bits[r])
            begin
                res[r*PIXEL_W +: PIXEL_W] = row[r*PIXEL_W +: PIXEL_W] | plane;
            end
            else
            begin
                res[r*PIXEL_W +: PIXEL_W] = row[r*PIXEL_W +: PIXEL_W] & ~plane;
            end
        end
        return res;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel(input logic [ROW_W-1:0] row,
                                                      input logic [2:0]       sel);
        return row[sel*PIXEL_W +: PIXEL_W];
    endfunction

endpackage

/* hdl/pcl_divider.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// POV column frame store divider
// Restoring divider that produces one quotient bit per clock cycle.
// ---------------------------------------------------------------------------
module pcl_divider
    import pcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  div_req_t              req,
    output div_rsp_t              rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    shifted;

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        shifted     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(DIVIDEND_W);
            quo_next    = dividend;
            rem_next    = '0;
            dsr_next    = req.divisor;
        end
        else if (active_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = DIVISOR_W'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* hdl/pov_column_led_frame_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// POV column frame store
// Frame store for a spinning column of eight RGB LEDs with a column timer.
// ---------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. Each
// transaction returns exactly one result, shown on the result ports for one
// cycle while done is high; the receiver cannot stall.
// Loading the latch, ticking, reading the rotation time, a zero timer divisor
// and any ignored strobe or out-of-range read show their result in the next
// cycle, and busy stays low, so such commands may be issued on every cycle.
// Color strobes and pixel reads first read a column row from the synchronous
// frame memory; a strobe then modifies the row and writes it back, and a
// pixel read picks one pixel from it. Setting the timer to a nonzero divisor
// runs a one-bit-per-cycle divider, and busy stays high until its quotient
// is checked and the result shown. When the column count changes, busy stays
// high while the columns below the new count are cleared one column per
// cycle, starting with the cycle that shows the result. After reset all
// MAX_COLUMNS columns are cleared likewise before any command is taken.
// ---------------------------------------------------------------------------
module pov_column_led_frame_store
    import pcl_pkg::*;
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int ROTATION_TIME = 2567,
    parameter int MIN_COLUMNS   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [7:0]  data_value,
    input  logic [10:0] pixel_address,
    output logic        done,
    output logic        column_event,
    output logic        rotation_event,
    output logic [7:0]  current_column,
    output logic [11:0] read_value,
    output logic        range_error
);

    localparam int CW         = $clog2(MAX_COLUMNS + 1);
    localparam int RW         = $clog2(MAX_COLUMNS);
    localparam int STORE_SIZE = MAX_COLUMNS * ROWS;

    logic [ROW_W-1:0] mem [MAX_COLUMNS];
    logic [ROW_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [RW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic             mem_re;
    logic [RW-1:0]    mem_raddr;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [2:0]       sel_reg, sel_next;
    logic [7:0]       latch_reg, latch_next;
    logic [CW-1:0]    index_reg, index_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             first_reg, first_next;
    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]    clr_limit_reg, clr_limit_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [CW:0]      index_inc;
    logic [CW-1:0]    tick_index;
    logic             tick_wrap;
    logic             addr_in_range;
    logic [CW-1:0]    new_count;
    logic             count_bad;

    pcl_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dividend (DIVIDEND_W'(ROTATION_TIME)),
        .req      (div_req),
        .rsp      (div_rsp)
    );

    always_comb
    begin
        index_inc = {1'b0, index_reg} + {{CW{1'b0}}, 1'b1};
        if (first_reg)
        begin
            tick_index = '0;
            tick_wrap  = 1'b1;
        end
        else if (index_inc >= {1'b0, count_reg})
        begin
            tick_index = '0;
            tick_wrap  = 1'b1;
        end
        else
        begin
            tick_index = index_inc[CW-1:0];
            tick_wrap  = 1'b0;
        end
        addr_in_range = ({21'b0, pixel_address} < 32'(STORE_SIZE));
        count_bad     = (div_rsp.quotient < DIVIDEND_W'(MIN_COLUMNS)) ||
                        (div_rsp.quotient > DIVIDEND_W'(MAX_COLUMNS));
        new_count     = CW'(div_rsp.quotient);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        sel_next       = sel_reg;
        latch_next     = latch_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_limit_next = clr_limit_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = row_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = row_reg;
        div_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next                    = op_t'(operation);
                    result_next                = '0;
                    result_next.current_column = 8'(index_reg);
                    case (op_t'(operation))
                        OP_LOAD_LATCH:
                        begin
                            latch_next = data_value;
                            done_next  = 1'b1;
                        end
                        OP_STROBE_RED, OP_STROBE_GREEN, OP_STROBE_BLUE:
                        begin
                            if (index_reg < count_reg)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = RW'(index_reg);
                                row_next   = RW'(index_reg);
                                state_next = ST_MEM;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_SET_TIMER:
                        begin
                            if (data_value == 8'd0)
                            begin
                                result_next.range_error = 1'b1;
                                done_next               = 1'b1;
                            end
                            else
                            begin
                                div_req.start   = 1'b1;
                                div_req.divisor = data_value;
                                state_next      = ST_DIV;
                            end
                        end
                        OP_TICK:
                        begin
                            first_next                 = 1'b0;
                            index_next                 = tick_index;
                            result_next.column_event   = 1'b1;
                            result_next.rotation_event = tick_wrap;
                            result_next.current_column = 8'(tick_index);
                            done_next                  = 1'b1;
                        end
                        OP_READ_PIXEL:
                        begin
                            if (addr_in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = RW'(pixel_address >> 3);
                                row_next   = RW'(pixel_address >> 3);
                                sel_next   = pixel_address[2:0];
                                state_next = ST_MEM;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_READ_ROTATION:
                        begin
                            result_next.read_value = 12'(ROTATION_TIME);
                            done_next              = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_MEM:
            begin
                if (op_reg == OP_READ_PIXEL)
                begin
                    result_next.read_value = {9'b0, pick_pixel(rd_data_reg, sel_reg)};
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = row_reg;
                    mem_wdata = apply_plane(rd_data_reg, plane_of(op_reg), latch_reg);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (count_bad)
                    begin
                        result_next.range_error = 1'b1;
                    end
                    else if (new_count != count_reg)
                    begin
                        count_next     = new_count;
                        clr_cnt_next   = '0;
                        clr_limit_next = new_count;
                        state_next     = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = RW'(clr_cnt_reg);
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_next == clr_limit_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            latch_reg     <= '0;
            index_reg     <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            clr_limit_reg <= CW'(MAX_COLUMNS);
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            latch_reg     <= latch_next;
            index_reg     <= index_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_limit_reg <= clr_limit_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        row_reg    <= row_next;
        sel_reg    <= sel_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign column_event   = result_reg.column_event;
    assign rotation_event = result_reg.rotation_event;
    assign current_column = result_reg.current_column;
    assign read_value     = result_reg.read_value;
    assign range_error    = result_reg.range_error;

endmodule

/* hdl/pcl_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// POV column frame store checker
// Port-level properties of the frame store, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "pov_column_led_frame_store_assert.svh"

module pcl_checker
    import pcl_pkg::*;
#(
    parameter int ROTATION_TIME = 2567
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  operation,
    input logic        done,
    input logic        column_event,
    input logic        rotation_event,
    input logic [11:0] read_value,
    input logic        range_error
);

    `PCL_ASSERT_NOW(a_rotation_needs_column, done && rotation_event, column_event)
    `PCL_ASSERT_NOW(a_tick_result_clean, done && column_event, (read_value == 12'd0) && !range_error)
    `PCL_ASSERT_NEXT(a_tick_one_cycle, start && !busy && (operation == OP_TICK), done && column_event)
    `PCL_ASSERT_NEXT(a_rotation_read, start && !busy && (operation == OP_READ_ROTATION), done && (read_value == 12'(ROTATION_TIME)))

endmodule

bind pov_column_led_frame_store pcl_checker #(.ROTATION_TIME(ROTATION_TIME)) u_pcl_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .done           (done),
    .column_event   (column_event),
    .rotation_event (rotation_event),
    .read_value     (read_value),
    .range_error    (range_error)
);
